// File: sv/assert_macros.svh
// Assertion macros for RTL files that check themselves; the top level uses them.
// Depends on nothing; each macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: condition");

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`endif

// File: sv/sfc3_pkg.sv
// Shared constants and pipeline payload types for the three-coin draw.
// Depends on nothing.
package sfc3_pkg;

   localparam int WORD_W    = 32;
   localparam int LINE_W    = 4;
   localparam int PATTERN_W = 3;

   localparam int WARMUP_ROUNDS_DEF = 12;
   localparam int DRAW_COUNT_DEF    = 3;

   localparam logic [WORD_W-1:0] INIT_A        = 32'h9E37_79B9;
   localparam logic [WORD_W-1:0] INIT_B        = 32'h243F_6A88;
   localparam logic [WORD_W-1:0] INIT_C        = 32'hB7E1_5162;
   localparam logic [WORD_W-1:0] ZERO_SEED_SUB = 32'd12345;
   // t/2^32 < 0.5 after rounding to a 24-bit mantissa
   localparam logic [WORD_W-1:0] YANG_LIMIT    = 32'h7FFF_FFC0;

   localparam logic [LINE_W-1:0] YANG_VALUE = 4'd3;
   localparam logic [LINE_W-1:0] YIN_VALUE  = 4'd2;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } gen_type;

   typedef struct packed {
      gen_type              gen;
      logic [PATTERN_W-1:0] pattern;
      logic [LINE_W-1:0]    sum;
   } stage_type;

endpackage

// File: sv/sfc3_seed.sv
// Seed stage: takes the seed magnitude (zero becomes ZERO_SEED_SUB) and loads the generator words.
// Depends on sfc3_pkg.
module sfc3_seed (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [sfc3_pkg::WORD_W-1:0]  in_seed,
   input  logic                         down_ready,
   output logic                         up_ready,
   output logic                         out_valid,
   output sfc3_pkg::stage_type          out_stage
);
   import sfc3_pkg::*;

   logic              valid_ff;
   stage_type         stage_ff;
   stage_type         stage_in;
   logic [WORD_W-1:0] mag;

   always_comb begin
      mag = in_seed[WORD_W-1] ? (~in_seed + WORD_W'(1)) : in_seed;
      if (mag == '0) begin
         mag = ZERO_SEED_SUB;
      end
      stage_in.gen.a   = INIT_A;
      stage_in.gen.b   = INIT_B;
      stage_in.gen.c   = INIT_C;
      stage_in.gen.d   = mag;
      stage_in.pattern = '0;
      stage_in.sum     = '0;
   end

   assign up_ready  = !valid_ff || down_ready;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: sv/sfc3_round.sv
// One generator round as a pipeline stage; draw rounds also score a coin.
// Depends on sfc3_pkg.
module sfc3_round #(
   parameter bit IS_DRAW  = 1'b0,
   parameter int DRAW_BIT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sfc3_pkg::stage_type in_stage,
   input  logic                down_ready,
   output logic                up_ready,
   output logic                out_valid,
   output sfc3_pkg::stage_type out_stage
);
   import sfc3_pkg::*;

   localparam logic [PATTERN_W-1:0] DRAW_MASK = PATTERN_W'(1) << DRAW_BIT;

   logic              valid_ff;
   stage_type         stage_ff;
   stage_type         stage_in;
   logic [WORD_W-1:0] d_next;
   logic [WORD_W-1:0] t_word;
   logic [WORD_W-1:0] c_rot;
   logic              yang;

   always_comb begin
      d_next = in_stage.gen.d + WORD_W'(1);
      t_word = in_stage.gen.a + in_stage.gen.b + d_next;
      c_rot  = {in_stage.gen.c[10:0], in_stage.gen.c[WORD_W-1:11]};
      yang   = t_word < YANG_LIMIT;

      stage_in.gen.a   = in_stage.gen.b ^ (in_stage.gen.b >> 9);
      stage_in.gen.b   = in_stage.gen.c + (in_stage.gen.c << 3);
      stage_in.gen.c   = c_rot + t_word;
      stage_in.gen.d   = d_next;
      stage_in.pattern = in_stage.pattern;
      stage_in.sum     = in_stage.sum;
      if (IS_DRAW) begin
         if (yang) begin
            stage_in.pattern = in_stage.pattern | DRAW_MASK;
            stage_in.sum     = in_stage.sum + YANG_VALUE;
         end else begin
            stage_in.sum     = in_stage.sum + YIN_VALUE;
         end
      end
   end

   assign up_ready  = !valid_ff || down_ready;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: sv/seeded_prng_three_coin_draw.sv
// Top level: seed stage followed by one pipeline stage per generator round.
// Depends on sfc3_pkg, sfc3_seed, sfc3_round and assert_macros.svh.
//
//   channel   ports                                    direction
//   req       req_valid req_stall req_seed             in
//   rsp       rsp_valid rsp_stall rsp_line_value       out
//             rsp_coin_pattern
//
// One item enters per cycle while req_stall is low; the path holds one register
// stage for the seed and one per generator round.
// Synchronous reset clears every stage's valid bit; payload is not reset.
// Each stage holds while the next is full and stalled, so empty stages
// still fill behind a stalled result.
`include "assert_macros.svh"

module seeded_prng_three_coin_draw #(
   parameter int WARMUP_ROUNDS = sfc3_pkg::WARMUP_ROUNDS_DEF,
   parameter int DRAW_COUNT    = sfc3_pkg::DRAW_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [sfc3_pkg::WORD_W-1:0] req_seed,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfc3_pkg::LINE_W-1:0]     rsp_line_value,
   output logic [sfc3_pkg::PATTERN_W-1:0]  rsp_coin_pattern
);
   import sfc3_pkg::*;

   localparam int ROUNDS   = WARMUP_ROUNDS + DRAW_COUNT;
   localparam int BASE_SUM = 2 * DRAW_COUNT;

   stage_type stages [0:ROUNDS];
   logic      valids [0:ROUNDS];
   logic      readys [0:ROUNDS+1];
   int        pattern_ones;

   assign readys[ROUNDS+1] = !rsp_stall;

   sfc3_seed u_seed (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_seed    ($unsigned(req_seed)),
      .down_ready (readys[1]),
      .up_ready   (readys[0]),
      .out_valid  (valids[0]),
      .out_stage  (stages[0])
   );

   for (genvar k = 0; k < ROUNDS; k++) begin : g_round
      sfc3_round #(
         .IS_DRAW  (k >= WARMUP_ROUNDS),
         .DRAW_BIT ((k >= WARMUP_ROUNDS) ? (k - WARMUP_ROUNDS) : 0)
      ) u_round (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valids[k]),
         .in_stage   (stages[k]),
         .down_ready (readys[k+2]),
         .up_ready   (readys[k+1]),
         .out_valid  (valids[k+1]),
         .out_stage  (stages[k+1])
      );
   end

   assign req_stall        = !readys[0];
   assign rsp_valid        = valids[ROUNDS];
   assign rsp_line_value   = stages[ROUNDS].sum;
   assign rsp_coin_pattern = stages[ROUNDS].pattern;
   assign pattern_ones     = $countones(rsp_coin_pattern);

   `ASSERT_IMPLY(a_sum_matches_pattern, rsp_valid, int'(rsp_line_value) == BASE_SUM + pattern_ones)
   `ASSERT_IMPLY(a_pattern_upper_clear, rsp_valid, (rsp_coin_pattern >> DRAW_COUNT) == '0)
   `ASSERT_IMPLY(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall)

endmodule
